FILE: src/base64_packed_hash_set_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packed hash set decoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BASE64_PACKED_HASH_SET_DECODER_TOP_ASSERT_SVH
`define BASE64_PACKED_HASH_SET_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define B64HS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Next-cycle implication.
`define B64HS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define B64HS_ASSERT_NOW(label, ante, cons)
`define B64HS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/b64hs_pkg.sv
// ---------------------------------------------------------------------------
// Packed hash set decoder package
// Shared widths, result codes and result types.
// ---------------------------------------------------------------------------
`default_nettype none

package b64hs_pkg;

    localparam int MAX_VALUE_BITS = 32;
    localparam int MIN_VALUE_BITS = 10;
    localparam int VALUE_W        = 32;
    localparam int WIDTH_W        = 6;
    localparam int RES_W          = 40;
    localparam int FILL_W         = 6;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(32);

    typedef enum logic [1:0] {
        STATUS_VALUE = 2'd0,
        STATUS_OK    = 2'd1,
        STATUS_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic               last;
    } result_t;

    // Up to two results per request: a value item, then the end result.
    typedef struct packed {
        logic    val_valid;
        result_t val_res;
        logic    end_valid;
        result_t end_res;
    } push_t;

endpackage

`default_nettype wire

FILE: src/b64hs_core.sv
// ---------------------------------------------------------------------------
// Packed hash set decoder core
// Character decode, bit reservoir, order check and end-of-string checks.
// ---------------------------------------------------------------------------
`default_nettype none

module b64hs_core
    import b64hs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         symbol,
    input  wire logic               final_symbol,
    input  wire logic [WIDTH_W-1:0] width_cfg,
    output push_t                   push
);

    logic [1:0]         pos_reg,     pos_next;
    logic [5:0]         partial_reg, partial_next;
    logic [RES_W-1:0]   res_reg,     res_next;
    logic [FILL_W-1:0]  fill_reg,    fill_next;
    logic [VALUE_W-1:0] prev_reg,    prev_next;
    logic               seen_reg,    seen_next;
    logic               err_reg,     err_next;

    logic               sym_ok;
    logic [5:0]         sextet;
    logic [WIDTH_W-1:0] w;
    logic [7:0]         byte_val;
    logic               have_byte;
    logic [5:0]         partial_mid;
    logic               err_now;
    logic               push_en;
    logic [RES_W-1:0]   res_or;
    logic [RES_W-1:0]   res_sh;
    logic [FILL_W-1:0]  fill_add;
    logic               take;
    logic [VALUE_W-1:0] val_mask;
    logic [VALUE_W-1:0] cur;
    logic               order_bad;
    logic               emit;
    logic [RES_W-1:0]   res_mid;
    logic [FILL_W-1:0]  fill_mid;
    logic               err_mid;
    logic               seen_mid;
    logic [VALUE_W-1:0] prev_mid;
    logic               str_ok;

    // Alphabet lookup
    always_comb
    begin
        sym_ok = 1'b1;
        sextet = '0;
        if (symbol >= 8'h41 && symbol <= 8'h5a)
            sextet = 6'(symbol - 8'h41);
        else if (symbol >= 8'h61 && symbol <= 8'h7a)
            sextet = 6'(symbol - 8'h61 + 8'd26);
        else if (symbol >= 8'h30 && symbol <= 8'h39)
            sextet = 6'(symbol - 8'h30 + 8'd52);
        else if (symbol == 8'h2b)
            sextet = 6'd62;
        else if (symbol == 8'h2f)
            sextet = 6'd63;
        else
            sym_ok = 1'b0;
    end

    // Clamp the configured width
    always_comb
    begin
        if (width_cfg < WIDTH_W'(MIN_VALUE_BITS))
            w = WIDTH_W'(MIN_VALUE_BITS);
        else if (width_cfg > WIDTH_W'(MAX_VALUE_BITS))
            w = WIDTH_W'(MAX_VALUE_BITS);
        else
            w = width_cfg;
    end

    // Assemble a byte from the held partial bits and the new sextet
    always_comb
    begin
        byte_val    = '0;
        have_byte   = 1'b1;
        partial_mid = '0;
        unique case (pos_reg)
            2'd0:
            begin
                partial_mid = sextet;
                have_byte   = 1'b0;
            end
            2'd1:
            begin
                byte_val    = {partial_reg[5:0], sextet[5:4]};
                partial_mid = {2'b00, sextet[3:0]};
            end
            2'd2:
            begin
                byte_val    = {partial_reg[3:0], sextet[5:2]};
                partial_mid = {4'b0000, sextet[1:0]};
            end
            default:
            begin
                byte_val    = {partial_reg[1:0], sextet};
                partial_mid = '0;
            end
        endcase
    end

    // Reservoir append and value extraction
    always_comb
    begin
        err_now   = err_reg | ~sym_ok;
        push_en   = have_byte & ~err_now;
        res_or    = res_reg | (RES_W'(byte_val) << fill_reg);
        fill_add  = fill_reg + FILL_W'(8);
        take      = (fill_add >= w);
        val_mask  = {VALUE_W{1'b1}} >> (WIDTH_W'(MAX_VALUE_BITS) - w);
        cur       = res_or[VALUE_W-1:0] & val_mask;
        res_sh    = res_or >> w;
        order_bad = seen_reg && (prev_reg >= cur);
        emit      = push_en && take && !order_bad;

        res_mid  = res_reg;
        fill_mid = fill_reg;
        if (push_en)
        begin
            res_mid  = take ? res_sh : res_or;
            fill_mid = take ? (fill_add - w) : fill_add;
        end
        err_mid  = err_now | (push_en & take & order_bad);
        seen_mid = seen_reg | emit;
        prev_mid = emit ? cur : prev_reg;

        str_ok = !err_mid && (pos_reg != 2'd0) && (partial_mid == '0)
                 && (fill_mid < FILL_W'(8)) && (res_mid == '0) && seen_mid;
    end

    // Next state: hold when idle, clear after the end of a string
    always_comb
    begin
        pos_next     = pos_reg;
        partial_next = partial_reg;
        res_next     = res_reg;
        fill_next    = fill_reg;
        prev_next    = prev_reg;
        seen_next    = seen_reg;
        err_next     = err_reg;
        if (accept)
        begin
            if (final_symbol)
            begin
                pos_next     = '0;
                partial_next = '0;
                res_next     = '0;
                fill_next    = '0;
                prev_next    = '0;
                seen_next    = 1'b0;
                err_next     = 1'b0;
            end
            else
            begin
                pos_next     = pos_reg + 2'd1;
                partial_next = partial_mid;
                res_next     = res_mid;
                fill_next    = fill_mid;
                prev_next    = prev_mid;
                seen_next    = seen_mid;
                err_next     = err_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            partial_reg <= '0;
            res_reg     <= '0;
            fill_reg    <= '0;
            prev_reg    <= '0;
            seen_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
            res_reg     <= res_next;
            fill_reg    <= fill_next;
            prev_reg    <= prev_next;
            seen_reg    <= seen_next;
            err_reg     <= err_next;
        end
    end

    always_comb
    begin
        push.val_valid      = accept & emit;
        push.val_res.value  = cur;
        push.val_res.status = STATUS_VALUE;
        push.val_res.last   = 1'b0;
        push.end_valid      = accept & final_symbol;
        push.end_res.value  = '0;
        push.end_res.status = str_ok ? STATUS_OK : STATUS_BAD;
        push.end_res.last   = 1'b1;
    end

endmodule

`default_nettype wire

FILE: src/b64hs_fifo.sv
// ---------------------------------------------------------------------------
// Packed hash set decoder result queue
// Small queue taking up to two results per cycle, releasing one unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module b64hs_fifo
    import b64hs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire push_t            push,
    input  wire logic             pop_stall,
    output logic                  pop_valid,
    output result_t               pop_res,
    output logic [CNT_W-1:0]      count
);

    result_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_reg, wr_next;
    logic [PTR_W-1:0]    rd_reg, rd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]          n_push;
    logic                pop;
    result_t             first_res;

    always_comb
    begin
        n_push    = {1'b0, push.val_valid} + {1'b0, push.end_valid};
        first_res = push.val_valid ? push.val_res : push.end_res;
        pop       = (cnt_reg != '0) && !pop_stall;
        wr_next   = wr_reg + PTR_W'(n_push);
        rd_next   = rd_reg + PTR_W'(pop);
        cnt_next  = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.val_valid || push.end_valid)
            mem[wr_reg] <= first_res;
        if (push.val_valid && push.end_valid)
            mem[wr_reg + PTR_W'(1)] <= push.end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign pop_valid = (cnt_reg != '0);
    assign pop_res   = mem[rd_reg];
    assign count     = cnt_reg;

endmodule

`default_nettype wire

FILE: src/base64_packed_hash_set_decoder_top.sv
// ---------------------------------------------------------------------------
// Packed hash set decoder top level
// Decodes a Base64 payload one character per request and emits the
// strictly increasing hash values it packs, then a valid/invalid verdict.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     symbol, final_symbol
//   output    out        out_valid / out_stall   value, status, last
//   config    in         cfg_valid / cfg_ready   bits_per_value
//
// One character is taken per cycle unless stalled. Its work (alphabet lookup,
// byte assembly, reservoir shift and order check) completes in the accept
// cycle, and its zero, one or two results enter a four-entry result queue;
// the first shows on the output the next cycle if the queue was empty. The
// output releases one result per cycle unless stalled. in_stall rises while
// the queue has fewer than two free entries, so a stalled output backs up
// into the input once three results are queued. Reset clears all string
// state and sets bits_per_value to 32; the config register is always ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "base64_packed_hash_set_decoder_top_assert.svh"

module base64_packed_hash_set_decoder_top
    import b64hs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // character requests
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         symbol,
    input  wire logic               final_symbol,
    // results
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [VALUE_W-1:0]      value,
    output logic [1:0]              status,
    output logic                    last,
    // width register
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [WIDTH_W-1:0] bits_per_value
);

    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               in_accept;
    push_t              push;
    result_t            head;
    logic [CNT_W-1:0]   q_count;

    // Config write: always ready, write only while the decoder is idle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next = width_reg;
        if (cfg_valid && cfg_ready)
            width_next = bits_per_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= WIDTH_RESET;
        else
            width_reg <= width_next;
    end

    // Hold off new characters unless the queue can absorb a value item
    // plus an end result.
    assign in_stall  = (q_count > CNT_W'(FIFO_DEPTH - 2));
    assign in_accept = in_valid & ~in_stall;

    b64hs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .symbol       (symbol),
        .final_symbol (final_symbol),
        .width_cfg    (width_reg),
        .push         (push)
    );

    b64hs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop_stall (out_stall),
        .pop_valid (out_valid),
        .pop_res   (head),
        .count     (q_count)
    );

    assign value  = head.value;
    assign status = head.status;
    assign last   = head.last;

    // An end request always leaves its verdict in the queue.
    `B64HS_ASSERT_NEXT(a_end_queued, in_accept && final_symbol, q_count != '0)
    // The queue never overflows.
    `B64HS_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CNT_W'(FIFO_DEPTH))
    // End results carry a zero value and a verdict code.
    `B64HS_ASSERT_NOW(a_end_shape, out_valid && last,
                      value == '0 && (status == STATUS_OK || status == STATUS_BAD))

endmodule

`default_nettype wire

FILE: tb/tb_base64_packed_hash_set_decoder_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packed hash set decoder testbench
// Drives Base64 payload characters into the decoder: a directed opening,
// then random well-formed, damaged and noise strings across several value
// widths. Input gaps and output stalls are random. A scoreboard predicts
// every hash value and end verdict and checks the results field by field.
// ---------------------------------------------------------------------------

class hash_set_checker;
    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    bit [5:0]  width_reg;
    bit [1:0]  grp_pos;
    bit [5:0]  partial;
    bit [39:0] reservoir;
    bit [5:0]  fill;
    bit [31:0] prev_value;
    bit        seen;
    bit        bad_string;

    b64hs_pkg::result_t awaited[$];
    int unsigned        mismatches;

    function new();
        width_reg  = 6'd32;
        mismatches = 0;
        clear_string();
    endfunction

    function void clear_string();
        grp_pos    = 2'd0;
        partial    = 6'd0;
        reservoir  = 40'd0;
        fill       = 6'd0;
        prev_value = 32'd0;
        seen       = 1'b0;
        bad_string = 1'b0;
    endfunction

    function int unsigned value_width();
        int unsigned w;
        w = width_reg;
        if (w < b64hs_pkg::MIN_VALUE_BITS) w = b64hs_pkg::MIN_VALUE_BITS;
        if (w > b64hs_pkg::MAX_VALUE_BITS) w = b64hs_pkg::MAX_VALUE_BITS;
        return w;
    endfunction

    function int sextet_of(logic [7:0] c);
        for (int i = 0; i < 64; i++)
            if (alphabet[i] == c) return i;
        return -1;
    endfunction

    // Append one byte to the bit reservoir; pull a value once enough bits sit there.
    function void take_byte(bit [7:0] byte_val);
        int unsigned        w;
        bit [31:0]          cur;
        b64hs_pkg::result_t r;
        w         = value_width();
        reservoir = reservoir | (40'(byte_val) << fill);
        fill      = fill + 6'd8;
        if (fill >= w) begin
            cur       = 32'(reservoir & ((40'd1 << w) - 40'd1));
            reservoir = reservoir >> w;
            fill      = fill - 6'(w);
            if (seen && prev_value >= cur) begin
                bad_string = 1'b1;
            end
            else begin
                prev_value = cur;
                seen       = 1'b1;
                r.value    = cur;
                r.status   = b64hs_pkg::STATUS_VALUE;
                r.last     = 1'b0;
                awaited.push_back(r);
            end
        end
    endfunction

    function void note_char(logic [7:0] sym, logic fin);
        int                 s;
        bit [5:0]           sx;
        bit [7:0]           byte_val;
        bit [1:0]           pos;
        bit                 ok;
        b64hs_pkg::result_t r;
        s        = sextet_of(sym);
        sx       = (s < 0) ? 6'd0 : 6'(s);
        pos      = grp_pos;
        byte_val = 8'd0;
        if (s < 0) bad_string = 1'b1;
        case (pos)
            2'd0:
            begin
                partial = sx;
            end
            2'd1:
            begin
                byte_val = {partial, sx[5:4]};
                partial  = {2'b00, sx[3:0]};
            end
            2'd2:
            begin
                byte_val = {partial[3:0], sx[5:2]};
                partial  = {4'b0000, sx[1:0]};
            end
            default:
            begin
                byte_val = {partial[1:0], sx};
                partial  = 6'd0;
            end
        endcase
        grp_pos = pos + 2'd1;
        if (pos != 2'd0 && !bad_string) take_byte(byte_val);
        if (fin) begin
            ok = !bad_string && pos != 2'd0 && partial == 6'd0 && fill < 6'd8
                 && reservoir == 40'd0 && seen;
            r.value  = 32'd0;
            r.status = ok ? b64hs_pkg::STATUS_OK : b64hs_pkg::STATUS_BAD;
            r.last   = 1'b1;
            awaited.push_back(r);
            clear_string();
        end
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] status, logic last);
        b64hs_pkg::result_t exp_r;
        if (awaited.size() == 0) begin
            $error("unexpected result: value %h status %0d last %0d", value, status, last);
            mismatches++;
            return;
        end
        exp_r = awaited.pop_front();
        if (value !== exp_r.value) begin
            $error("value: expected %h, actual %h", exp_r.value, value);
            mismatches++;
        end
        if (status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status);
            mismatches++;
        end
        if (last !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, last);
            mismatches++;
        end
    endfunction
endclass

module tb_base64_packed_hash_set_decoder_top;
    import b64hs_pkg::*;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 8;     // result queue is only four deep
    localparam int ITEM_TARGET   = 1450;

    typedef enum int {
        FLAVOR_CLEAN,
        FLAVOR_NOISE,
        FLAVOR_BAD_CHAR,
        FLAVOR_DISORDER,
        FLAVOR_TRUNCATED,
        FLAVOR_EXTRA_CHAR,
        FLAVOR_DIRTY_PAD
    } string_flavor_e;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [7:0]         symbol         = 8'd0;
    logic               final_symbol   = 1'b0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
    logic               last;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [WIDTH_W-1:0] bits_per_value = WIDTH_RESET;

    hash_set_checker chk = new();

    int unsigned chars_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    // receiver stall pattern state
    int unsigned stall_pct = 0;
    int unsigned mode_left = 0;
    int unsigned run_left  = 0;
    logic        run_stall = 1'b0;

    base64_packed_hash_set_decoder_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol         (symbol),
        .final_symbol   (final_symbol),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .status         (status),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .bits_per_value (bits_per_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Observe both channels at the edge, before any nonblocking update lands.
    // Check the output first: it can only carry results of earlier requests.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) chk.check_result(value, status, last);
            if (in_valid && !in_stall) chk.note_char(symbol, final_symbol);
        end
    end

    // Receiver: pick a stall rate for each random-length mode, then hold stall
    // or release it in short runs at that rate. A zero rate gives long
    // stretches with no stall at all.
    always @(posedge clk)
    begin
        if (mode_left == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            mode_left = $urandom_range(100, 400);
        end
        mode_left--;
        if (run_left == 0) begin
            run_left  = $urandom_range(1, 8);
            run_stall = ($urandom_range(0, 99) < stall_pct);
        end
        run_left--;
        out_stall <= run_stall;
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** base64_packed_hash_set_decoder_top: FAILED **");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one character request and hold it until it is taken. Requests go
    // out in bursts; between bursts drop valid for a random gap.
    task automatic send_char(input logic [7:0] sym, input logic fin);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        in_valid     <= 1'b1;
        symbol       <= sym;
        final_symbol <= fin;
        do @(posedge clk); while (in_stall);
        burst_left--;
        chars_sent++;
    endtask

    // Send a whole string, marking its last character as final.
    task automatic send_chars(input logic [7:0] chars[$]);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    // Drop valid and wait until every predicted result has come back, then
    // let the pipeline settle. The first edge lets the monitor catch up.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        drain();
        cfg_valid      <= 1'b1;
        bits_per_value <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        chk.width_reg  = w;
    endtask

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < 26)      return "A" + s;
        else if (s < 52) return "a" + (s - 26);
        else if (s < 62) return "0" + (s - 52);
        else if (s == 62) return "+";
        else             return "/";
    endfunction

    // Pack values little-endian, w bits each; the last byte is zero-padded.
    function automatic void pack_values(input logic [31:0] vals[$], input int unsigned w,
                                        output logic [7:0] bytes[$]);
        logic [63:0] acc;
        int unsigned nbits;
        acc   = 64'd0;
        nbits = 0;
        bytes.delete();
        foreach (vals[i]) begin
            acc   = acc | ((64'(vals[i]) & ((64'd1 << w) - 64'd1)) << nbits);
            nbits = nbits + w;
            while (nbits >= 8) begin
                bytes.push_back(acc[7:0]);
                acc   = acc >> 8;
                nbits = nbits - 8;
            end
        end
        if (nbits != 0) bytes.push_back(acc[7:0]);
    endfunction

    // Base64 without padding: a short tail group gives two or three characters.
    function automatic void encode_bytes(input logic [7:0] bytes[$], output logic [7:0] chars[$]);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int         n;
        n = bytes.size();
        chars.delete();
        for (int i = 0; i < n; i += 3) begin
            b0 = bytes[i];
            b1 = (i + 1 < n) ? bytes[i + 1] : 8'd0;
            b2 = (i + 2 < n) ? bytes[i + 2] : 8'd0;
            chars.push_back(sextet_char(b0[7:2]));
            chars.push_back(sextet_char({b0[1:0], b1[7:4]}));
            if (i + 1 < n) chars.push_back(sextet_char({b1[3:0], b2[7:6]}));
            if (i + 2 < n) chars.push_back(sextet_char(b2[5:0]));
        end
    endfunction

    // Strictly increasing values that fit w bits; sometimes touch zero or the top.
    function automatic void pick_values(input int unsigned w, input int unsigned k,
                                        output logic [31:0] vals[$]);
        logic [63:0] top;
        logic [63:0] step;
        logic [63:0] cur;
        top  = (64'd1 << w) - 64'd1;
        step = top / k;
        cur  = {32'd0, $urandom} % step;
        if ($urandom_range(0, 7) == 0) cur = 64'd0;
        vals.delete();
        for (int i = 0; i < k; i++) begin
            if (i != 0) cur = cur + 64'd1 + ({32'd0, $urandom} % step);
            vals.push_back(cur[31:0]);
        end
        if ($urandom_range(0, 7) == 0) vals[k - 1] = top[31:0];
    endfunction

    // Mostly clean strings with random content; the rest damaged or pure noise.
    task automatic send_random_string(input int unsigned w);
        logic [31:0]    vals[$];
        logic [7:0]     bytes[$];
        logic [7:0]     chars[$];
        int unsigned    k;
        int unsigned    j;
        string_flavor_e flavor;
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        pick_values(w, k, vals);
        if ($urandom_range(0, 9) < 7) flavor = FLAVOR_CLEAN;
        else flavor = string_flavor_e'($urandom_range(FLAVOR_NOISE, FLAVOR_DIRTY_PAD));

        if (flavor == FLAVOR_DISORDER) begin
            if (k >= 2) begin
                j       = $urandom_range(1, k - 1);
                vals[j] = $urandom_range(0, 1) ? vals[j - 1] : vals[0];
            end
            else begin
                vals.push_back(vals[0]);
            end
        end
        pack_values(vals, w, bytes);
        if (flavor == FLAVOR_DIRTY_PAD)
            bytes[bytes.size() - 1] = bytes[bytes.size() - 1] | 8'($urandom_range(1, 255));
        encode_bytes(bytes, chars);

        case (flavor)
            FLAVOR_BAD_CHAR:
            begin
                chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
            FLAVOR_TRUNCATED:
            begin
                repeat ($urandom_range(1, 2))
                    if (chars.size() > 1) void'(chars.pop_back());
            end
            FLAVOR_EXTRA_CHAR:
            begin
                chars.push_back(sextet_char(6'($urandom_range(0, 63))));
            end
            FLAVOR_NOISE:
            begin
                chars.delete();
                repeat ($urandom_range(1, 10))
                    chars.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                         : sextet_char(6'($urandom_range(0, 63))));
            end
            default:
            begin
            end
        endcase
        send_chars(chars);
    endtask

    initial
    begin
        logic [WIDTH_W-1:0] phase_widths[$];
        logic [31:0]        vals[$];
        logic [7:0]         bytes[$];
        logic [7:0]         chars[$];
        int unsigned        quota;

        // Widths per random phase: both out-of-range ends, both legal ends,
        // a few in between and two drawn at random.
        phase_widths = '{6'd63, 6'd0, 6'd32, 6'd21, 6'd10, 6'd13, 6'd27};
        phase_widths.push_back(WIDTH_W'($urandom_range(0, 63)));
        phase_widths.push_back(WIDTH_W'($urandom_range(0, 63)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset width of 32 bits.
        // Smallest and largest value in one valid string.
        pick_values(32, 1, vals);
        vals = '{32'h0000_0000, 32'hffff_ffff};
        pack_values(vals, 32, bytes);
        encode_bytes(bytes, chars);
        send_chars(chars);
        // Lone final character.
        send_chars('{"Q"});
        // Unused low bits of the final character are set, and no value appears.
        send_chars('{"z", "+", "9"});
        // Characters outside the alphabet at both byte extremes.
        send_chars('{8'h00, 8'hff});

        // Directed, at the narrowest width.
        write_width(6'd10);
        // Repeated value breaks the strict ordering.
        pack_values('{32'd3, 32'd3}, 10, bytes);
        encode_bytes(bytes, chars);
        send_chars(chars);
        // Extra byte of set bits makes a second value; set bits stay behind.
        pack_values('{32'h2a5}, 10, bytes);
        bytes.push_back(8'hff);
        encode_bytes(bytes, chars);
        send_chars(chars);
        // Padding bits after the last value are not zero.
        pack_values('{32'h155}, 10, bytes);
        bytes[1] = bytes[1] | 8'h80;
        encode_bytes(bytes, chars);
        send_chars(chars);

        // Random phases, each closed on a string boundary before the next width.
        foreach (phase_widths[p]) begin
            write_width(phase_widths[p]);
            quota = chars_sent + ITEM_TARGET / phase_widths.size();
            while (chars_sent < quota) send_random_string(chk.value_width());
        end

        drain();
        if (chk.awaited.size() != 0) begin
            $error("%0d expected results never arrived", chk.awaited.size());
            chk.mismatches++;
        end
        if (chk.mismatches == 0)
            $display("** base64_packed_hash_set_decoder_top: PASSED **");
        else
            $display("** base64_packed_hash_set_decoder_top: FAILED **");
        $finish;
    end

endmodule
